FILE: hw/rtl/lifo_pkg.sv
`default_nettype none

package lifo_pkg;

    localparam int DATA_W        = 32;
    localparam int INDEX_W       = 7;
    localparam int OCC_W         = 8;
    localparam int DEFAULT_DEPTH = 128;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_CHANGE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
        logic change;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/lifo_cell.sv
`default_nettype none

module lifo_cell #(
    parameter int DEPTH = lifo_pkg::DEFAULT_DEPTH,
    parameter int POS   = 0
) (
    input  wire                                   i_clk,
    input  lifo_pkg::t_cell_ctrl                  i_ctrl,
    input  wire  [$clog2(DEPTH)-1:0]              i_target,
    input  wire  signed [lifo_pkg::DATA_W-1:0]    i_value,
    input  wire  signed [lifo_pkg::DATA_W-1:0]    i_from_up,
    input  wire  signed [lifo_pkg::DATA_W-1:0]    i_from_down,
    output logic signed [lifo_pkg::DATA_W-1:0]    o_data
);
    import lifo_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        priority if (i_ctrl.push) begin
            n_data = i_from_up;
        end else if (i_ctrl.pop) begin
            n_data = i_from_down;
        end else if (i_ctrl.change && (i_target == PW'(POS))) begin
            n_data = i_value;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: hw/rtl/lifo_stack_with_indexed_write.sv
`default_nettype none

// Bounded stack of DEPTH signed 32-bit words built as a row of cells, with the top
// entry always held in the first cell. Push shifts every cell one place down and pop
// one place up, while change writes the single cell holding the entry whose position,
// counted from the bottom of the stack, is given by the index. Each accepted
// transaction yields exactly one result transaction carrying the data, status and
// new occupancy. A push or pop moves the whole row of cells together; the result
// register is the only stage, so a new command is accepted whenever the result
// register is empty or being drained in the same cycle, sustaining one command
// per clock.
module lifo_stack_with_indexed_write #(
    parameter int DEPTH = lifo_pkg::DEFAULT_DEPTH
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_valid,
    output logic                                     o_ready,
    input  wire  [1:0]                               i_cmd,
    input  wire  signed [lifo_pkg::DATA_W-1:0]       i_value,
    input  wire  [lifo_pkg::INDEX_W-1:0]             i_index,
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic signed [lifo_pkg::DATA_W-1:0]       o_data,
    output logic [1:0]                               o_status,
    output logic [lifo_pkg::OCC_W-1:0]               o_occupancy
);
    import lifo_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);
    localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    logic signed [DATA_W-1:0] n_out_data;
    t_status                  r_out_status;
    t_status                  n_out_status;
    logic [OCC_W-1:0]         r_out_occ;
    logic [OCC_W-1:0]         n_out_occ;

    logic                     w_accept;
    t_cell_ctrl               w_ctrl;
    logic [PW-1:0]            w_target;
    logic [WW-1:0]            w_index_x;
    logic [WW-1:0]            w_count_x;
    logic [WW-1:0]            w_target_x;
    logic signed [DATA_W-1:0] w_cell [DEPTH];

    assign o_ready    = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_index_x  = WW'(i_index);
    assign w_count_x  = WW'(r_count);
    assign w_target_x = w_count_x - WW'(1) - w_index_x;
    assign w_target   = w_target_x[PW-1:0];

    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        w_ctrl       = '0;
        if (w_accept) begin
            n_out_valid  = 1'b1;
            n_out_data   = '0;
            n_out_status = ST_OK;
            unique case (t_cmd'(i_cmd))
                CMD_PUSH: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_out_status = ST_FULL;
                    end else begin
                        w_ctrl.push = 1'b1;
                        n_count     = r_count + CW'(1);
                    end
                end
                CMD_POP: begin
                    if (r_count == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        w_ctrl.pop = 1'b1;
                        n_count    = r_count - CW'(1);
                        n_out_data = w_cell[0];
                    end
                end
                CMD_PEEK: begin
                    if (r_count == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_data = w_cell[0];
                    end
                end
                CMD_CHANGE: begin
                    if (w_index_x >= w_count_x) begin
                        n_out_status = ST_INDEX;
                    end else begin
                        w_ctrl.change = 1'b1;
                    end
                end
                default: begin
                    n_out_status = ST_INDEX;
                end
            endcase
            n_out_occ = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_up;
            logic signed [DATA_W-1:0] w_down;
            if (g == 0) begin : g_first
                assign w_up = i_value;
            end else begin : g_mid_up
                assign w_up = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_down = w_cell[g];
            end else begin : g_mid_down
                assign w_down = w_cell[g+1];
            end
            lifo_cell #(
                .DEPTH (DEPTH),
                .POS   (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_target    (w_target),
                .i_value     (i_value),
                .i_from_up   (w_up),
                .i_from_down (w_down),
                .o_data      (w_cell[g])
            );
        end
    endgenerate

    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

endmodule

`default_nettype wire
